// ----- rtl/core/gbm_pkg.sv -----
// shared types and constants of the lognormal path step block
// no dependencies
`default_nettype none

package gbm_pkg;

    localparam int unsigned CFG_INDEX_BITS = 3;
    localparam int unsigned CFG_DATA_BITS  = 48;

    localparam logic [CFG_INDEX_BITS-1:0] CFG_INITIAL_PRICE = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DRIFT         = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_DIFFUSION     = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_STEPS         = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ANTITHETIC    = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_EMIT_PATH     = 3'd5;

    localparam logic [29:0] LOG2E_Q28     = 30'd387270501;
    localparam logic [29:0] LN2_Q30       = 30'd744261118;
    localparam logic [3:0]  TAYLOR_TERMS  = 4'd14;
    localparam logic [3:0]  TAYLOR_FIRST  = 4'd1;
    localparam logic [9:0]  Q30_SHIFT     = 10'd30;
    localparam logic [35:0] X_LIMIT       = 36'h4_0000_0000;
    localparam int unsigned INDEX_BITS    = 16;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ERR,
        ST_START,
        ST_XCALC,
        ST_LOGM,
        ST_TCALC,
        ST_TAY_MUL,
        ST_TAY_REC,
        ST_TAY_ACC,
        ST_PP_LO,
        ST_PP_HI,
        ST_SCALE,
        ST_FINISH
    } t_state;

    typedef struct packed {
        logic       accept;
        logic       push_err;
        logic       load_init;
        logic       push_init;
        logic       calc_x;
        logic       calc_y;
        logic       calc_t;
        logic       tay_mul;
        logic       tay_rec;
        logic       tay_acc;
        logic       pp_lo;
        logic       pp_hi;
        logic       scale;
        logic       finish;
        logic       sel_dn;
        logic [3:0] k;
    } t_cmd;

    typedef struct packed {
        logic cfg_err;
        logic cnt_zero;
        logic emit;
        logic room;
    } t_status;

    // floor(2^32 / k)
    function automatic logic [32:0] recip_q32(input logic [3:0] k);
        logic [32:0] r;
        unique case (k)
            4'd1:    r = 33'h1_0000_0000;
            4'd2:    r = 33'd2147483648;
            4'd3:    r = 33'd1431655765;
            4'd4:    r = 33'd1073741824;
            4'd5:    r = 33'd858993459;
            4'd6:    r = 33'd715827882;
            4'd7:    r = 33'd613566756;
            4'd8:    r = 33'd536870912;
            4'd9:    r = 33'd477218588;
            4'd10:   r = 33'd429496729;
            4'd11:   r = 33'd390451572;
            4'd12:   r = 33'd357913941;
            4'd13:   r = 33'd330382099;
            4'd14:   r = 33'd306783378;
            default: r = 33'd0;
        endcase
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- rtl/core/gbm_ctrl.sv -----
// sequencer of the lognormal path step: one item at a time, up path then mirror path
// depends on gbm_pkg
`default_nettype none

module gbm_ctrl (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_in_valid,
    output logic                   o_in_stall,
    input  wire gbm_pkg::t_status  i_status,
    output gbm_pkg::t_cmd          o_cmd
);
    import gbm_pkg::*;

    t_state     r_state, n_state;
    logic [3:0] r_k, n_k;
    logic       r_dn, n_dn;
    logic       w_accept;

    assign o_in_stall = !((r_state == ST_IDLE) && i_status.room);
    assign w_accept   = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= TAYLOR_FIRST;
            r_dn    <= 1'b0;
        end else begin
            r_state <= n_state;
            r_k     <= n_k;
            r_dn    <= n_dn;
        end
    end

    always_comb begin
        n_state = r_state;
        n_k     = r_k;
        n_dn    = r_dn;
        o_cmd   = '0;
        o_cmd.sel_dn = r_dn;
        o_cmd.k      = r_k;
        o_cmd.accept = w_accept;
        unique case (r_state)
            ST_IDLE: begin
                if (w_accept) begin
                    n_state = i_status.cfg_err ? ST_ERR : ST_START;
                end
            end
            ST_ERR: begin
                o_cmd.push_err = 1'b1;
                n_state = ST_IDLE;
            end
            ST_START: begin
                o_cmd.load_init = i_status.cnt_zero;
                o_cmd.push_init = i_status.cnt_zero && i_status.emit;
                n_state = ST_XCALC;
            end
            ST_XCALC: begin
                o_cmd.calc_x = 1'b1;
                n_dn = 1'b0;
                n_state = ST_LOGM;
            end
            ST_LOGM: begin
                o_cmd.calc_y = 1'b1;
                n_state = ST_TCALC;
            end
            ST_TCALC: begin
                o_cmd.calc_t = 1'b1;
                n_k = TAYLOR_FIRST;
                n_state = ST_TAY_MUL;
            end
            ST_TAY_MUL: begin
                o_cmd.tay_mul = 1'b1;
                n_state = ST_TAY_REC;
            end
            ST_TAY_REC: begin
                o_cmd.tay_rec = 1'b1;
                n_state = ST_TAY_ACC;
            end
            ST_TAY_ACC: begin
                o_cmd.tay_acc = 1'b1;
                if (r_k == TAYLOR_TERMS) begin
                    n_state = ST_PP_LO;
                end else begin
                    n_k = r_k + 4'd1;
                    n_state = ST_TAY_MUL;
                end
            end
            ST_PP_LO: begin
                o_cmd.pp_lo = 1'b1;
                n_state = ST_PP_HI;
            end
            ST_PP_HI: begin
                o_cmd.pp_hi = 1'b1;
                n_state = ST_SCALE;
            end
            ST_SCALE: begin
                o_cmd.scale = 1'b1;
                if (r_dn) begin
                    n_state = ST_FINISH;
                end else begin
                    n_dn = 1'b1;
                    n_state = ST_LOGM;
                end
            end
            ST_FINISH: begin
                o_cmd.finish = 1'b1;
                n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
    end

endmodule

`default_nettype wire

// ----- rtl/core/gbm_dpath.sv -----
// datapath of the lognormal path step: config registers, exponent unit, price scaling,
// path state and result queue; depends on gbm_pkg
`default_nettype none

module gbm_dpath #(
    parameter int unsigned PRICE_BITS  = 48,
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    input  wire  [gbm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire  [gbm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  wire  signed [SAMPLE_BITS-1:0]       i_normal_sample,
    input  wire  gbm_pkg::t_cmd                 i_cmd,
    output gbm_pkg::t_status                    o_status,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [PRICE_BITS-1:0]               o_price_up,
    output logic [PRICE_BITS-1:0]               o_price_down,
    output logic [gbm_pkg::INDEX_BITS-1:0]      o_step_index,
    output logic                                o_last_of_path,
    output logic                                o_saturated,
    output logic                                o_config_error
);
    import gbm_pkg::*;

    localparam int unsigned SAMPLE_FRAC = SAMPLE_BITS - 4;
    localparam int unsigned DPROD_BITS  = 32 + SAMPLE_BITS;
    localparam logic [PRICE_BITS-1:0] PRICE_MAX = {PRICE_BITS{1'b1}};

    // config registers
    logic [PRICE_BITS-1:0] r_init;
    logic signed [31:0]    r_drift;
    logic [30:0]           r_diff;
    logic [COUNT_BITS-1:0] r_steps;
    logic                  r_anti;
    logic                  r_emit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_init  <= PRICE_BITS'(48'd16777216);
            r_drift <= '0;
            r_diff  <= '0;
            r_steps <= COUNT_BITS'(1);
            r_anti  <= 1'b0;
            r_emit  <= 1'b1;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_INITIAL_PRICE: r_init  <= PRICE_BITS'(i_cfg_data);
                CFG_DRIFT:         r_drift <= i_cfg_data[31:0];
                CFG_DIFFUSION:     r_diff  <= i_cfg_data[30:0];
                CFG_STEPS:         r_steps <= COUNT_BITS'(i_cfg_data[15:0]);
                CFG_ANTITHETIC:    r_anti  <= i_cfg_data[0];
                CFG_EMIT_PATH:     r_emit  <= i_cfg_data[0];
                default: ;
            endcase
        end
    end

    // path state
    logic [PRICE_BITS-1:0] r_pup, r_pdn;
    logic [COUNT_BITS-1:0] r_cnt;
    logic                  r_sat_up, r_sat_dn;
    logic signed [SAMPLE_BITS-1:0] r_z;

    // exponent unit
    logic signed [35:0] r_x_up, r_x_dn;
    logic signed [65:0] r_yp;
    logic signed [9:0]  r_n;
    logic [29:0]        r_t;
    logic [30:0]        r_term, r_v, r_q;
    logic [31:0]        r_sum;
    logic [63:0]        r_pa, r_pb;

    logic signed [DPROD_BITS-1:0] w_dprod, w_dsh;
    logic signed [35:0] w_d, w_drift36, w_xu, w_xd, w_xsel;
    logic signed [65:0] w_yprod;
    logic [37:0]        w_y;
    logic [57:0]        w_tprod;
    logic [60:0]        w_vprod;
    logic [63:0]        w_qprod;
    logic [34:0]        w_qk, w_rem;
    logic [30:0]        w_qfix;
    logic [63:0]        w_p64;
    logic [PRICE_BITS-1:0] w_psel;
    logic [95:0]        w_prod;
    logic signed [9:0]  w_s;
    logic [6:0]         w_samt;
    logic [223:0]       w_wl;
    logic [95:0]        w_wr;
    logic [PRICE_BITS-1:0] w_newp;
    logic               w_newsat;

    function automatic logic signed [35:0] clamp_x(input logic signed [35:0] x);
        logic signed [35:0] r;
        if (x > $signed(X_LIMIT)) begin
            r = $signed(X_LIMIT);
        end else if (x < -$signed(X_LIMIT)) begin
            r = -$signed(X_LIMIT);
        end else begin
            r = x;
        end
        return r;
    endfunction

    assign w_dprod   = $signed({1'b0, r_diff}) * r_z;
    assign w_dsh     = w_dprod >>> SAMPLE_FRAC;
    assign w_d       = w_dsh[35:0];
    assign w_drift36 = {{4{r_drift[31]}}, r_drift};
    assign w_xu      = w_drift36 + w_d;
    assign w_xd      = w_drift36 - w_d;
    assign w_xsel    = i_cmd.sel_dn ? r_x_dn : r_x_up;
    assign w_yprod   = w_xsel * $signed({1'b0, LOG2E_Q28});
    assign w_y       = r_yp[65:28];
    assign w_tprod   = w_y[27:0] * LN2_Q30;
    assign w_vprod   = r_term * r_t;
    assign w_qprod   = r_v * recip_q32(i_cmd.k);
    assign w_qk      = r_q * i_cmd.k;
    assign w_rem     = {4'b0, r_v} - w_qk;
    assign w_qfix    = (w_rem >= {31'b0, i_cmd.k}) ? r_q + 31'd1 : r_q;
    assign w_psel    = i_cmd.sel_dn ? r_pdn : r_pup;
    assign w_p64     = 64'(w_psel);
    assign w_prod    = {32'b0, r_pa} + {r_pb, 32'b0};
    assign w_s       = r_n - $signed(Q30_SHIFT);
    assign w_samt    = w_s[9] ? 7'(-w_s) : w_s[6:0];
    assign w_wl      = {128'b0, w_prod} << w_samt;
    assign w_wr      = w_prod >> w_samt;

    always_comb begin
        if (w_psel == '0) begin
            w_newp   = '0;
            w_newsat = 1'b0;
        end else if (!w_s[9]) begin
            w_newsat = |w_wl[223:PRICE_BITS];
            w_newp   = w_newsat ? PRICE_MAX : w_wl[PRICE_BITS-1:0];
        end else begin
            w_newsat = |w_wr[95:PRICE_BITS];
            w_newp   = w_newsat ? PRICE_MAX : w_wr[PRICE_BITS-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) r_z <= i_normal_sample;
        if (i_cmd.calc_x) begin
            r_x_up <= clamp_x(w_xu);
            r_x_dn <= clamp_x(w_xd);
        end
        if (i_cmd.calc_y) r_yp <= w_yprod;
        if (i_cmd.calc_t) begin
            r_n    <= w_y[37:28];
            r_t    <= w_tprod[57:28];
            r_term <= 31'h4000_0000;
            r_sum  <= 32'h4000_0000;
        end
        if (i_cmd.tay_mul) r_v <= w_vprod[60:30];
        if (i_cmd.tay_rec) r_q <= w_qprod[62:32];
        if (i_cmd.tay_acc) begin
            r_term <= w_qfix;
            r_sum  <= r_sum + {1'b0, w_qfix};
        end
        if (i_cmd.pp_lo) r_pa <= w_p64[31:0] * r_sum;
        if (i_cmd.pp_hi) r_pb <= w_p64[63:32] * r_sum;
    end

    logic [COUNT_BITS:0] w_idx;
    logic                w_last;
    assign w_idx  = {1'b0, r_cnt} + 1'b1;
    assign w_last = w_idx >= {1'b0, r_steps};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pup <= '0;
            r_pdn <= '0;
            r_cnt <= '0;
        end else begin
            if (i_cmd.load_init) begin
                r_pup <= r_init;
                r_pdn <= r_init;
            end
            if (i_cmd.scale) begin
                if (i_cmd.sel_dn) begin
                    r_pdn    <= w_newp;
                    r_sat_dn <= w_newsat;
                end else begin
                    r_pup    <= w_newp;
                    r_sat_up <= w_newsat;
                end
            end
            if (i_cmd.finish) begin
                r_cnt <= w_last ? '0 : w_idx[COUNT_BITS-1:0];
            end
        end
    end

    // result queue
    logic [PRICE_BITS-1:0] r_fq_up  [0:3];
    logic [PRICE_BITS-1:0] r_fq_dn  [0:3];
    logic [INDEX_BITS-1:0] r_fq_idx [0:3];
    logic [2:0]            r_fq_flg [0:3];
    logic [1:0]            r_wp, r_rp;
    logic [2:0]            r_fcnt;
    logic                  w_push, w_pop;
    logic [PRICE_BITS-1:0] w_up, w_dn;
    logic [INDEX_BITS-1:0] w_ix;
    logic [2:0]            w_flg;

    always_comb begin
        w_push = 1'b0;
        w_up   = '0;
        w_dn   = '0;
        w_ix   = '0;
        w_flg  = '0;
        priority if (i_cmd.push_err) begin
            w_push = 1'b1;
            w_flg  = 3'b001;
        end else if (i_cmd.push_init) begin
            w_push = 1'b1;
            w_up   = r_init;
            w_dn   = r_anti ? r_init : '0;
        end else if (i_cmd.finish && (r_emit || w_last)) begin
            w_push = 1'b1;
            w_up   = r_pup;
            w_dn   = r_anti ? r_pdn : '0;
            w_ix   = INDEX_BITS'(w_idx);
            w_flg  = {w_last, r_sat_up || (r_anti && r_sat_dn), 1'b0};
        end
    end

    assign o_out_valid = (r_fcnt != 3'd0);
    assign w_pop       = o_out_valid && !i_out_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp   <= '0;
            r_rp   <= '0;
            r_fcnt <= '0;
        end else begin
            if (w_push) r_wp <= r_wp + 2'd1;
            if (w_pop)  r_rp <= r_rp + 2'd1;
            r_fcnt <= r_fcnt + {2'b0, w_push} - {2'b0, w_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_fq_up[r_wp]  <= w_up;
            r_fq_dn[r_wp]  <= w_dn;
            r_fq_idx[r_wp] <= w_ix;
            r_fq_flg[r_wp] <= w_flg;
        end
    end

    assign o_price_up     = r_fq_up[r_rp];
    assign o_price_down   = r_fq_dn[r_rp];
    assign o_step_index   = r_fq_idx[r_rp];
    assign o_last_of_path = r_fq_flg[r_rp][2];
    assign o_saturated    = r_fq_flg[r_rp][1];
    assign o_config_error = r_fq_flg[r_rp][0];

    assign o_status.cfg_err  = (r_init == '0) || (r_diff == '0) || (r_steps == '0);
    assign o_status.cnt_zero = (r_cnt == '0);
    assign o_status.emit     = r_emit;
    assign o_status.room     = (r_fcnt <= 3'd2);

endmodule

`default_nettype wire

// ----- rtl/core/gbm_antithetic_path_step.sv -----
// top level of the lognormal path step with antithetic mirror path
// depends on gbm_pkg, gbm_ctrl, gbm_dpath
//
// input channel: i_in_valid / o_in_stall carry one normal sample (Q4.12) per transfer
// output channel: o_out_valid / i_out_stall carry one price result per transfer
// config channel: i_cfg_valid / o_cfg_ready write register i_cfg_index with i_cfg_data;
//   the user must write only while the block is idle, the block itself does not enforce it; ready is always high
// each sample gives one result, two at path start in whole-path mode (initial price first),
//   none in final-only mode before the last step; bad settings give one error result
// one item runs the control steps (idle, start, x calculation, finish) plus, for each of the two paths,
//   an exponent chain (log2e multiply, ln2 multiply, 14 Taylor terms, each a step on the term multiplier,
//   one on the reciprocal multiplier and an accumulate, both shared by the paths), two partial products and scale
// an error item passes only through the error state; an error result or initial price is queued in the
//   cycle after the transfer, a stepped price in the finish state after both paths are scaled
// results wait in a 4-entry queue; a new sample is taken while idle and at least two entries are free,
//   so a stalled receiver holds off input once fewer than two entries are free
// synchronous reset restores register defaults, clears the path and empties the queue
`default_nettype none

module gbm_antithetic_path_step #(
    parameter int unsigned PRICE_BITS  = 48,
    parameter int unsigned SAMPLE_BITS = 16,
    parameter int unsigned COUNT_BITS  = 16
) (
    input  wire                                 i_clk,
    input  wire                                 i_rst_n,
    input  wire                                 i_cfg_valid,
    output logic                                o_cfg_ready,
    input  wire  [gbm_pkg::CFG_INDEX_BITS-1:0]  i_cfg_index,
    input  wire  [gbm_pkg::CFG_DATA_BITS-1:0]   i_cfg_data,
    input  wire                                 i_in_valid,
    output logic                                o_in_stall,
    input  wire  signed [SAMPLE_BITS-1:0]       i_normal_sample,
    output logic                                o_out_valid,
    input  wire                                 i_out_stall,
    output logic [PRICE_BITS-1:0]               o_price_up,
    output logic [PRICE_BITS-1:0]               o_price_down,
    output logic [gbm_pkg::INDEX_BITS-1:0]      o_step_index,
    output logic                                o_last_of_path,
    output logic                                o_saturated,
    output logic                                o_config_error
);
    import gbm_pkg::*;

    t_cmd    w_cmd;
    t_status w_status;

    assign o_cfg_ready = 1'b1;

    gbm_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_stall (o_in_stall),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    gbm_dpath #(
        .PRICE_BITS  (PRICE_BITS),
        .SAMPLE_BITS (SAMPLE_BITS),
        .COUNT_BITS  (COUNT_BITS)
    ) u_dpath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cfg_valid     (i_cfg_valid),
        .i_cfg_index     (i_cfg_index),
        .i_cfg_data      (i_cfg_data),
        .i_normal_sample (i_normal_sample),
        .i_cmd           (w_cmd),
        .o_status        (w_status),
        .o_out_valid     (o_out_valid),
        .i_out_stall     (i_out_stall),
        .o_price_up      (o_price_up),
        .o_price_down    (o_price_down),
        .o_step_index    (o_step_index),
        .o_last_of_path  (o_last_of_path),
        .o_saturated     (o_saturated),
        .o_config_error  (o_config_error)
    );

endmodule

`default_nettype wire

// ----- rtl/core/gbm_checker.sv -----
// port-level checks of the lognormal path step, bound to the top level
// depends on gbm_antithetic_path_step
`default_nettype none

module gbm_props #(
    parameter int unsigned PRICE_BITS = 48
) (
    input wire                  i_clk,
    input wire                  i_rst_n,
    input wire                  o_out_valid,
    input wire                  i_out_stall,
    input wire [PRICE_BITS-1:0] o_price_up,
    input wire [PRICE_BITS-1:0] o_price_down,
    input wire [15:0]           o_step_index,
    input wire                  o_last_of_path,
    input wire                  o_saturated,
    input wire                  o_config_error
);

    // error result carries nothing else
    a_err_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_config_error) |->
        (o_price_up == '0 && o_price_down == '0 && o_step_index == 16'd0 &&
         !o_last_of_path && !o_saturated))
        else $error("error result with nonzero fields");

    // initial price is never last and never clipped
    a_init_flags: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_config_error && o_step_index == 16'd0) |->
        (!o_last_of_path && !o_saturated))
        else $error("initial price with step flags");

    // a clipped price reads full scale on one of the paths
    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_saturated) |->
        (o_price_up == {PRICE_BITS{1'b1}} || o_price_down == {PRICE_BITS{1'b1}}))
        else $error("saturated flag without full scale price");

    // a stalled result holds
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && i_out_stall) |=>
        (o_out_valid && $stable(o_price_up) && $stable(o_step_index)))
        else $error("stalled result changed");

endmodule

bind gbm_antithetic_path_step gbm_props #(.PRICE_BITS(PRICE_BITS)) u_gbm_props (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_price_up     (o_price_up),
    .o_price_down   (o_price_down),
    .o_step_index   (o_step_index),
    .o_last_of_path (o_last_of_path),
    .o_saturated    (o_saturated),
    .o_config_error (o_config_error)
);

`default_nettype wire
